FILE: rtl/rrit_pkg.sv
// Shared types, constants and codes for the ring record index tracker.
// Used by the channel interfaces and by every module of the block.
package rrit_pkg;

	localparam int unsigned MAX_SLOTS       = 1024;
	localparam int unsigned MAX_GAP         = 63;
	localparam int unsigned CMD_QUEUE_DEPTH = 2;

	localparam int unsigned NUM_W   = 32;
	localparam int unsigned SLOT_W  = 10;
	localparam int unsigned CAP_W   = 11;
	// An append runs at most MAX_GAP + 1 slots.
	localparam int unsigned COUNT_W = $clog2(MAX_GAP + 2);
	// The remainder unit reduces a value below capacity + MAX_GAP + 1, so the
	// quotient stays below (MAX_GAP + 1) / 2 + 2 at the smallest capacity.
	localparam int unsigned MOD_STEPS = $clog2((MAX_GAP + 1) / 2 + 2);

	typedef logic [NUM_W-1:0]   number_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [CAP_W-1:0]   cap_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam number_t ALL_ONES   = '1;
	localparam number_t TOP_NUMBER = number_t'(32'hFFFF_FFFE);
	localparam cap_t    CAP_RESET  = cap_t'(1024);
	localparam cap_t    CAP_MIN    = cap_t'(2);
	localparam cap_t    CAP_MAX    = cap_t'(MAX_SLOTS);

	typedef enum logic [1:0] {
		ACT_APPEND    = 2'd0,
		ACT_TO_SLOT   = 2'd1,
		ACT_TO_NUMBER = 2'd2,
		ACT_UNUSED    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_HELD   = 3'd1,
		ST_SLOT_RANGE = 3'd2,
		ST_BEFORE_END = 3'd3,
		ST_SPACE_FULL = 3'd4,
		ST_GAP_LARGE  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		LY_EMPTY          = 4'd0,
		LY_ONE_AT_ZERO    = 4'd1,
		LY_ONE_MID        = 4'd2,
		LY_ONE_AT_END     = 4'd3,
		LY_PART_FROM_ZERO = 4'd4,
		LY_FULL_CONTIG    = 4'd5,
		LY_PART_MID       = 4'd6,
		LY_PART_TO_END    = 4'd7,
		LY_PART_SPLIT     = 4'd8,
		LY_PART_SPLIT_END = 4'd9,
		LY_FULL_SPLIT     = 4'd10,
		LY_FULL_SPLIT_END = 4'd11
	} layout_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EVAL,
		BK_PREP,
		BK_MOD,
		BK_COMMIT,
		BK_EMIT,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		action_t op;
		logic    auto_next;
		number_t number;
		slot_t   slot;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef struct packed {
		logic start;
		cap_t dividend;
		cap_t divisor;
	} mod_req_t;

	typedef struct packed {
		logic  done;
		slot_t rem;
	} mod_rsp_t;

	typedef struct packed {
		status_t status;
		slot_t   slot_out;
		number_t number_out;
		logic    is_target;
		logic    last;
		layout_t layout_class;
		cap_t    held_count;
	} result_t;

endpackage

FILE: rtl/rrit_if.sv
// Channel interfaces of the ring record index tracker: requests, results and
// the capacity write port. Depends on rrit_pkg.
interface rrit_req_if;
	import rrit_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [NUM_W-1:0]    record_number;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, action, record_number, slot, input ready);
	modport sink   (input valid, action, record_number, slot, output ready);
endinterface

interface rrit_rsp_if;
	import rrit_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [SLOT_W-1:0] slot_out;
	logic [NUM_W-1:0]  number_out;
	logic              is_target;
	logic              last;
	logic [3:0]        layout_class;
	logic [CAP_W-1:0]  held_count;

	modport source (output valid, status, slot_out, number_out, is_target, last,
		layout_class, held_count, input ready);
	modport sink   (input valid, status, slot_out, number_out, is_target, last,
		layout_class, held_count, output ready);
endinterface

interface rrit_cfg_if;
	import rrit_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] ring_capacity;

	modport source (output valid, ring_capacity, input ready);
	modport sink   (input valid, ring_capacity, output ready);
endinterface

FILE: rtl/rrit_front.sv
// Front end: takes request beats, decodes them into commands and holds them
// in a short queue for the back end. Depends on rrit_pkg and rrit_req_if.
module rrit_front #(
	parameter int unsigned DEPTH = rrit_pkg::CMD_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	rrit_req_if.sink            req,
	output rrit_pkg::cmd_head_t head,
	input  logic                pop
);
	import rrit_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	cmd_t             cmd_in;

	assign req.ready = (count_q != CNT_W'(DEPTH));
	assign push      = req.valid && req.ready;

	always_comb begin
		cmd_in.op        = action_t'(req.action);
		// An all-ones number on an append stands for the next record.
		cmd_in.auto_next = (req.record_number == ALL_ONES);
		cmd_in.number    = req.record_number;
		cmd_in.slot      = req.slot;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

endmodule

FILE: rtl/rrit_mod_unit.sv
// Multi-cycle remainder unit: reduces a small value modulo the ring capacity
// by restoring subtraction, one quotient bit a cycle. Depends on rrit_pkg.
module rrit_mod_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  rrit_pkg::mod_req_t request,
	output rrit_pkg::mod_rsp_t result
);
	import rrit_pkg::*;

	localparam int unsigned STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
	localparam int unsigned SH_W   = CAP_W + MOD_STEPS;

	cap_t              rem_q;
	cap_t              divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [SH_W-1:0]   shifted;
	logic              fits;

	assign shifted = SH_W'(divisor_q) << step_q;
	assign fits    = (SH_W'(rem_q) >= shifted);

	always_ff @(posedge clk) begin
		if (request.start) begin
			rem_q     <= request.dividend;
			divisor_q <= request.divisor;
		end else if (busy_q && fits) begin
			rem_q <= rem_q - shifted[CAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (request.start) begin
				step_q <= STEP_W'(MOD_STEPS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	assign result.done = done_q;
	assign result.rem  = rem_q[SLOT_W-1:0];

endmodule

FILE: rtl/rrit_back.sv
// Back end: holds the ring bookkeeping, carries out one command at a time and
// drives the result register. Depends on rrit_pkg, rrit_if and rrit_mod_unit.
module rrit_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rrit_pkg::cmd_head_t head,
	output logic                pop,
	rrit_rsp_if.source          rsp,
	rrit_cfg_if.sink            cfg
);
	import rrit_pkg::*;

	// Ring state
	cap_t    cap_q;
	logic    empty_q;
	number_t oldest_num_q;
	number_t newest_num_q;
	number_t slot_zero_q;
	slot_t   oldest_slot_q;
	slot_t   newest_slot_q;
	cap_t    held_q;

	// Command in progress
	back_state_t state_q;
	back_state_t state_d;
	cmd_t        cmd_q;
	status_t     stat_q;
	number_t     target_q;
	count_t      k_q;
	cap_t        off_q;
	number_t     em_num_q;
	slot_t       em_slot_q;
	count_t      em_left_q;

	// Result register
	logic    rsp_valid_q;
	result_t rsp_q;

	logic     can_load;
	logic     load;
	result_t  load_res;
	result_t  finish_res;
	result_t  emit_res;
	layout_t  layout;
	slot_t    last_slot;
	status_t  eval_status;
	count_t   eval_k;
	number_t  eval_target;
	cap_t     eval_off;
	number_t  diff_num;
	logic     gap_large;
	cap_t     cfg_cap;
	mod_req_t mod_request;
	mod_rsp_t mod_result;

	// Commit values
	slot_t   ns_f;
	cap_t    held_sum;
	logic    dropped;
	slot_t   os_drop;
	number_t on_drop;
	cap_t    fin_slot_sum;

	rrit_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (mod_request),
		.result  (mod_result)
	);

	assign cfg.ready = 1'b1;
	assign can_load  = !rsp_valid_q || rsp.ready;
	assign last_slot = slot_t'(cap_q - CAP_W'(1));

	always_comb begin
		if (cfg.ring_capacity < CAP_MIN) begin
			cfg_cap = CAP_MIN;
		end else if (cfg.ring_capacity > CAP_MAX) begin
			cfg_cap = CAP_MAX;
		end else begin
			cfg_cap = cfg.ring_capacity;
		end
	end

	// Layout class of the current state.
	always_comb begin
		priority if (empty_q) begin
			layout = LY_EMPTY;
		end else if (held_q == CAP_W'(1)) begin
			if (oldest_slot_q == '0) begin
				layout = LY_ONE_AT_ZERO;
			end else if (oldest_slot_q == last_slot) begin
				layout = LY_ONE_AT_END;
			end else begin
				layout = LY_ONE_MID;
			end
		end else if (oldest_slot_q < newest_slot_q) begin
			if (oldest_slot_q == '0) begin
				layout = (newest_slot_q < last_slot) ? LY_PART_FROM_ZERO : LY_FULL_CONTIG;
			end else begin
				layout = (newest_slot_q < last_slot) ? LY_PART_MID : LY_PART_TO_END;
			end
		end else if (CAP_W'(oldest_slot_q) > CAP_W'(newest_slot_q) + CAP_W'(1)) begin
			layout = (oldest_slot_q < last_slot) ? LY_PART_SPLIT : LY_PART_SPLIT_END;
		end else begin
			layout = (oldest_slot_q < last_slot) ? LY_FULL_SPLIT : LY_FULL_SPLIT_END;
		end
	end

	// Checks and offsets of the command in cmd_q.
	always_comb begin
		diff_num    = cmd_q.number - newest_num_q;
		eval_status = ST_OK;
		eval_k      = count_t'(1);
		eval_target = cmd_q.number;
		eval_off    = cap_t'(cmd_q.number - oldest_num_q);
		gap_large   = 1'b0;
		unique case (cmd_q.op)
			ACT_APPEND: begin
				if (cmd_q.auto_next) begin
					eval_target = empty_q ? '0 : newest_num_q + NUM_W'(1);
					eval_k      = count_t'(1);
				end else if (empty_q) begin
					gap_large = (cmd_q.number > NUM_W'(MAX_GAP));
					eval_k    = cmd_q.number[COUNT_W-1:0] + count_t'(1);
				end else begin
					gap_large = (diff_num > NUM_W'(MAX_GAP + 1));
					eval_k    = diff_num[COUNT_W-1:0];
				end
				priority if (!empty_q && !cmd_q.auto_next && cmd_q.number <= newest_num_q) begin
					eval_status = ST_BEFORE_END;
				end else if (!empty_q && newest_num_q == TOP_NUMBER) begin
					eval_status = ST_SPACE_FULL;
				end else if (gap_large) begin
					eval_status = ST_GAP_LARGE;
				end else begin
					eval_status = ST_OK;
				end
			end
			ACT_TO_SLOT: begin
				if (empty_q || cmd_q.number < oldest_num_q || cmd_q.number > newest_num_q) begin
					eval_status = ST_NOT_HELD;
				end
			end
			ACT_TO_NUMBER: begin
				if (cmd_q.slot >= oldest_slot_q) begin
					eval_off = CAP_W'(cmd_q.slot) - CAP_W'(oldest_slot_q);
				end else begin
					eval_off = CAP_W'(cmd_q.slot) + cap_q - CAP_W'(oldest_slot_q);
				end
				priority if (CAP_W'(cmd_q.slot) >= cap_q) begin
					eval_status = ST_SLOT_RANGE;
				end else if (empty_q) begin
					eval_status = ST_NOT_HELD;
				end else begin
					eval_status = ST_OK;
				end
			end
			ACT_UNUSED: begin
				eval_status = ST_NOT_HELD;
			end
		endcase
	end

	// Single result of a lookup, a refused append or an unused action.
	always_comb begin
		fin_slot_sum           = CAP_W'(oldest_slot_q) + off_q;
		finish_res             = '0;
		finish_res.status      = stat_q;
		finish_res.number_out  = ALL_ONES;
		finish_res.last        = 1'b1;
		finish_res.layout_class = layout;
		finish_res.held_count  = held_q;
		if (stat_q == ST_OK) begin
			if (cmd_q.op == ACT_TO_SLOT) begin
				if (fin_slot_sum >= cap_q) begin
					fin_slot_sum = fin_slot_sum - cap_q;
				end
				finish_res.slot_out   = fin_slot_sum[SLOT_W-1:0];
				finish_res.number_out = cmd_q.number;
			end else if (off_q < held_q) begin
				finish_res.slot_out   = cmd_q.slot;
				finish_res.number_out = oldest_num_q + NUM_W'(off_q);
			end else begin
				finish_res.status = ST_NOT_HELD;
			end
		end
	end

	always_comb begin
		emit_res              = '0;
		emit_res.status       = ST_OK;
		emit_res.slot_out     = em_slot_q;
		emit_res.number_out   = em_num_q;
		emit_res.is_target    = (em_left_q == count_t'(1));
		emit_res.last         = (em_left_q == count_t'(1));
		emit_res.layout_class = layout;
		emit_res.held_count   = held_q;
	end

	// Final state of an append, once the remainder unit has the newest slot.
	always_comb begin
		ns_f     = mod_result.rem;
		held_sum = held_q + CAP_W'(k_q);
		dropped  = (held_sum > cap_q);
		os_drop  = (CAP_W'(ns_f) + CAP_W'(1) == cap_q) ? '0 : ns_f + SLOT_W'(1);
		on_drop  = target_q - NUM_W'(cap_q) + NUM_W'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:   if (head.valid) state_d = BK_EVAL;
			BK_EVAL: begin
				if (cmd_q.op == ACT_APPEND && eval_status == ST_OK) begin
					state_d = BK_PREP;
				end else begin
					state_d = BK_FINISH;
				end
			end
			BK_PREP:   state_d = BK_MOD;
			BK_MOD:    if (mod_result.done) state_d = BK_COMMIT;
			BK_COMMIT: state_d = BK_EMIT;
			BK_EMIT:   if (can_load && em_left_q == count_t'(1)) state_d = BK_IDLE;
			BK_FINISH: if (can_load) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop                  = 1'b0;
		load                 = 1'b0;
		load_res             = finish_res;
		mod_request.start    = 1'b0;
		mod_request.divisor  = cap_q;
		mod_request.dividend = empty_q ? CAP_W'(k_q) - CAP_W'(1)
			: CAP_W'(newest_slot_q) + CAP_W'(k_q);
		unique case (state_q)
			BK_IDLE:   pop = head.valid;
			BK_PREP:   mod_request.start = 1'b1;
			BK_EMIT: begin
				load     = can_load;
				load_res = emit_res;
			end
			BK_FINISH: load = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (state_q == BK_EVAL) begin
			stat_q   <= eval_status;
			k_q      <= eval_k;
			target_q <= eval_target;
			off_q    <= eval_off;
		end
		if (state_q == BK_PREP) begin
			// The first slot follows the newest one, or is slot 0 in an empty ring.
			em_num_q  <= target_q - NUM_W'(k_q) + NUM_W'(1);
			em_slot_q <= empty_q ? '0
				: (CAP_W'(newest_slot_q) + CAP_W'(1) == cap_q) ? '0
				: newest_slot_q + SLOT_W'(1);
			em_left_q <= k_q;
		end else if (state_q == BK_EMIT && load) begin
			em_num_q  <= em_num_q + NUM_W'(1);
			em_slot_q <= (CAP_W'(em_slot_q) + CAP_W'(1) == cap_q) ? '0 : em_slot_q + SLOT_W'(1);
			em_left_q <= em_left_q - count_t'(1);
		end
		if (load) begin
			rsp_q <= load_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			rsp_valid_q   <= 1'b0;
			cap_q         <= CAP_RESET;
			empty_q       <= 1'b1;
			oldest_num_q  <= ALL_ONES;
			newest_num_q  <= ALL_ONES;
			slot_zero_q   <= '0;
			oldest_slot_q <= '0;
			newest_slot_q <= '0;
			held_q        <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				// A capacity write empties the ring.
				cap_q         <= cfg_cap;
				empty_q       <= 1'b1;
				oldest_num_q  <= ALL_ONES;
				newest_num_q  <= ALL_ONES;
				slot_zero_q   <= '0;
				oldest_slot_q <= '0;
				newest_slot_q <= '0;
				held_q        <= '0;
			end else if (state_q == BK_COMMIT) begin
				empty_q       <= 1'b0;
				newest_num_q  <= target_q;
				newest_slot_q <= ns_f;
				// Slot 0 always holds the newest number less the newest slot.
				slot_zero_q   <= target_q - NUM_W'(ns_f);
				held_q        <= dropped ? cap_q : held_sum;
				if (dropped) begin
					oldest_num_q  <= on_drop;
					oldest_slot_q <= os_drop;
				end else if (empty_q) begin
					oldest_num_q  <= '0;
					oldest_slot_q <= '0;
				end
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.slot_out     = rsp_q.slot_out;
	assign rsp.number_out   = rsp_q.number_out;
	assign rsp.is_target    = rsp_q.is_target;
	assign rsp.last         = rsp_q.last;
	assign rsp.layout_class = rsp_q.layout_class;
	assign rsp.held_count   = rsp_q.held_count;

endmodule

FILE: rtl/ring_record_index_tracker_unit.sv
// Top level of the ring record index tracker: command queue front end and
// executing back end. Depends on rrit_pkg, rrit_if, rrit_front and rrit_back.
//
// Usage. Request beats on req carry an action, a record number and a slot.
// A successful append yields one result beat per slot it fills, the gap
// slots first and the target slot last (is_target and last high); every
// other request yields exactly one result beat with last high. Each result
// carries the layout class and the record count as they stand after the
// whole request. Requests are executed one at a time. A successful append
// first waits on the remainder unit that places the newest slot in the ring,
// and then emits one slot per cycle while rsp is not stalled.
// The front queue holds two requests, so req can take up to two requests
// while the back end works. When rsp is stalled the result register holds its
// beat and the back end waits; the queue keeps taking requests until it is full.
// Reset empties the ring and sets the capacity to 1024. A beat on cfg sets
// the capacity (clamped to 2..1024) and empties the ring; it is always ready
// and is to be sent only while no request is outstanding.
module ring_record_index_tracker_unit #(
	parameter int unsigned QUEUE_DEPTH = rrit_pkg::CMD_QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	rrit_req_if.sink   req,
	rrit_rsp_if.source rsp,
	rrit_cfg_if.sink   cfg
);
	import rrit_pkg::*;

	cmd_head_t head;
	logic      pop;

	rrit_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	rrit_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("command taken from an empty queue");

	a_target_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_target |-> rsp.last && rsp.status == ST_OK)
		else $error("target slot beat is not the final beat of its request");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |->
			rsp.last && rsp.number_out == ALL_ONES && rsp.slot_out == '0)
		else $error("error beat carries a slot or record number");

	a_layout_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.layout_class == LY_EMPTY) == (rsp.held_count == '0)))
		else $error("layout class and record count disagree on emptiness");

endmodule
